// File: hdl/lpfd_pkg.sv
// Shared constants, types and codes for the length-prefixed frame deframer.
`default_nettype none

package lpfd_pkg;

   // Payload buffer depth in bytes (valid range 1..64).
   localparam int MAX_PAYLOAD = 64;
   localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int LEN_W   = 16;
   localparam int CHECK_W = 16;

   localparam logic [KIND_W-1:0] KIND_DATA    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LEN_ERR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

   typedef enum logic [6:0] {
      PH_HUNT   = 7'b0000001,
      PH_LEN_LO = 7'b0000010,
      PH_LEN_HI = 7'b0000100,
      PH_DATA   = 7'b0001000,
      PH_CHK_HI = 7'b0010000,
      PH_CHK_LO = 7'b0100000,
      PH_DRAIN  = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  payload_byte;
      logic               last;
      logic [LEN_W-1:0]   frame_length;
      logic [CHECK_W-1:0] check_word;
   } rsp_word_type;

endpackage : lpfd_pkg

`default_nettype wire

// File: hdl/lpfd_if.sv
// Valid/ready channel interfaces for received bytes and deframed result words.
`default_nettype none

interface lpfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface : lpfd_req_if

interface lpfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic        last;
   logic [15:0] frame_length;
   logic [15:0] check_word;

   modport source (output valid, output kind, output payload_byte, output last,
                   output frame_length, output check_word, input ready);
   modport sink   (input valid, input kind, input payload_byte, input last,
                   input frame_length, input check_word, output ready);
endinterface : lpfd_rsp_if

`default_nettype wire

// File: hdl/length_prefixed_frame_deframer_core.sv
// Top level of the length-prefixed frame deframer: parser, payload buffer and readout.
//
// Usage:
//  - req_ch carries one received byte per word (valid/ready). The parser hunts for
//    the start byte held in the csr register (csr_wr_en / csr_wr_data, reset 0),
//    then takes a 16-bit length (low byte first), the payload, and a 16-bit check
//    word (high byte first). The check word is not verified, only passed on.
//  - rsp_ch carries result words. A length above the buffer size gives one
//    length-error word at once; a zero length gives one empty-frame word after the
//    check word. Otherwise, after the check word, the buffered payload is played
//    back one word per cycle while rsp_ch.ready is high, with last set on the final byte.
//  - Framing bytes are taken one per cycle. The last check byte of a non-empty
//    frame opens the readout: req_ch.ready stays low until the last payload byte
//    is read (synchronous RAM, one read per cycle while the output path has room).
//    The first payload word passes the phase, RAM read and output registers.
//  - An output register plus a one-word skid stage absorb the RAM read latency,
//    so a stalled receiver just holds the readout; nothing is dropped.
//  - Bytes that would emit a word (length high, check low) wait on req_ch until
//    the output path is empty or draining.
//  - Reset (synchronous) returns to hunting and empties the output path; the
//    payload buffer is not cleared, since only bytes of the current frame are read.
`default_nettype none

module length_prefixed_frame_deframer_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        csr_wr_en,
   input  wire [lpfd_pkg::BYTE_W-1:0] csr_wr_data,
   lpfd_req_if.sink                   req_ch,
   lpfd_rsp_if.source                 rsp_ch
);
   import lpfd_pkg::*;

   // configuration
   logic [BYTE_W-1:0]  start_byte_ff;

   // parser state
   phase_type          phase_ff, phase_in;
   logic [LEN_W-1:0]   frame_len_ff, frame_len_in;
   logic [CNT_W-1:0]   byte_count_ff, byte_count_in;
   logic [CHECK_W-1:0] check_hold_ff, check_hold_in;
   logic [CNT_W-1:0]   rd_addr_ff, rd_addr_in;

   // payload buffer
   logic [BYTE_W-1:0]  payload_mem [MAX_PAYLOAD];
   logic [BYTE_W-1:0]  rd_data_ff;
   logic               rd_valid_ff;
   logic               rd_last_ff;

   // output path
   rsp_word_type       out_word_ff, out_word_in;
   logic               out_valid_ff, out_valid_in;
   rsp_word_type       skid_word_ff, skid_word_in;
   logic               skid_valid_ff, skid_valid_in;

   logic               accept;
   logic               out_free;
   logic               path_clear;
   logic               emits;
   logic               in_load;
   rsp_word_type       in_word;
   rsp_word_type       rd_word;
   logic               wr_en;
   logic               rd_issue;
   logic [1:0]         occ;
   logic [1:0]         occ_after;
   logic [LEN_W-1:0]   full_len;
   logic [LEN_W-1:0]   count_next;
   logic [LEN_W-1:0]   rd_next;

   // handshake
   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign path_clear = out_free && !skid_valid_ff && !rd_valid_ff;
   assign emits      = (phase_ff == PH_LEN_HI) || (phase_ff == PH_CHK_LO);
   assign req_ch.ready = (phase_ff != PH_DRAIN) && (!emits || path_clear);
   assign accept     = req_ch.valid && req_ch.ready;

   assign full_len   = {req_ch.rx_byte, frame_len_ff[7:0]};
   assign count_next = LEN_W'(byte_count_ff) + LEN_W'(1);
   assign rd_next    = LEN_W'(rd_addr_ff) + LEN_W'(1);

   // readout issue: at most two words in flight past the RAM
   assign occ       = {1'b0, out_valid_ff} + {1'b0, skid_valid_ff} + {1'b0, rd_valid_ff};
   assign occ_after = occ - {1'b0, out_valid_ff && rsp_ch.ready};
   assign rd_issue  = (phase_ff == PH_DRAIN) && (occ_after < 2'd2);

   assign wr_en = accept && (phase_ff == PH_DATA);

   // parser
   always_comb begin
      phase_in      = phase_ff;
      frame_len_in  = frame_len_ff;
      byte_count_in = byte_count_ff;
      check_hold_in = check_hold_ff;
      rd_addr_in    = rd_addr_ff;
      in_load       = 1'b0;
      in_word       = '0;

      if (accept) begin
         case (phase_ff)
            PH_LEN_LO: begin
               frame_len_in = {8'd0, req_ch.rx_byte};
               phase_in     = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               frame_len_in  = full_len;
               byte_count_in = '0;
               if (full_len > LEN_W'(MAX_PAYLOAD)) begin
                  // too long for the buffer: report and drop the frame
                  in_load              = 1'b1;
                  in_word.kind         = KIND_LEN_ERR;
                  in_word.last         = 1'b1;
                  in_word.frame_length = full_len;
                  phase_in             = PH_HUNT;
               end else if (full_len == '0) begin
                  phase_in = PH_CHK_HI;
               end else begin
                  phase_in = PH_DATA;
               end
            end
            PH_DATA: begin
               byte_count_in = byte_count_ff + CNT_W'(1);
               if (count_next >= frame_len_ff) begin
                  phase_in = PH_CHK_HI;
               end
            end
            PH_CHK_HI: begin
               check_hold_in = {8'd0, req_ch.rx_byte};
               phase_in      = PH_CHK_LO;
            end
            PH_CHK_LO: begin
               check_hold_in = {check_hold_ff[7:0], req_ch.rx_byte};
               if (frame_len_ff == '0) begin
                  in_load            = 1'b1;
                  in_word.kind       = KIND_EMPTY;
                  in_word.last       = 1'b1;
                  in_word.check_word = {check_hold_ff[7:0], req_ch.rx_byte};
                  phase_in           = PH_HUNT;
               end else begin
                  rd_addr_in = '0;
                  phase_in   = PH_DRAIN;
               end
            end
            default: begin
               if (req_ch.rx_byte == start_byte_ff) begin
                  phase_in      = PH_LEN_LO;
                  frame_len_in  = '0;
                  byte_count_in = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end

      if (rd_issue) begin
         rd_addr_in = rd_addr_ff + CNT_W'(1);
         if (rd_next == frame_len_ff) begin
            phase_in = PH_HUNT;
         end
      end
   end

   // RAM read data lands with the frame fields of the current frame
   always_comb begin
      rd_word              = '0;
      rd_word.kind         = KIND_DATA;
      rd_word.payload_byte = rd_data_ff;
      rd_word.last         = rd_last_ff;
      rd_word.frame_length = frame_len_ff;
      rd_word.check_word   = check_hold_ff;
   end

   // output register and skid stage
   always_comb begin
      out_word_in   = out_word_ff;
      out_valid_in  = out_valid_ff;
      skid_word_in  = skid_word_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (in_load) begin
            out_word_in  = in_word;
            out_valid_in = 1'b1;
         end else if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            out_valid_in  = 1'b1;
            skid_word_in  = rd_word;
            skid_valid_in = rd_valid_ff;
         end else if (rd_valid_ff) begin
            out_word_in  = rd_word;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (rd_valid_ff) begin
         skid_word_in  = rd_word;
         skid_valid_in = 1'b1;
      end
   end

   // payload buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_mem[byte_count_ff[ADDR_W-1:0]] <= req_ch.rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         rd_data_ff <= payload_mem[rd_addr_ff[ADDR_W-1:0]];
         rd_last_ff <= (rd_next == frame_len_ff);
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= '0;
         phase_ff      <= PH_HUNT;
         frame_len_ff  <= '0;
         byte_count_ff <= '0;
         check_hold_ff <= '0;
         rd_addr_ff    <= '0;
         rd_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            start_byte_ff <= csr_wr_data;
         end
         phase_ff      <= phase_in;
         frame_len_ff  <= frame_len_in;
         byte_count_ff <= byte_count_in;
         check_hold_ff <= check_hold_in;
         rd_addr_ff    <= rd_addr_in;
         rd_valid_ff   <= rd_issue;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.kind         = out_word_ff.kind;
   assign rsp_ch.payload_byte = out_word_ff.payload_byte;
   assign rsp_ch.last         = out_word_ff.last;
   assign rsp_ch.frame_length = out_word_ff.frame_length;
   assign rsp_ch.check_word   = out_word_ff.check_word;

   // skid stage only holds a word while the output register is full
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word without output word");

   // a landing read never meets a full skid behind a stalled output
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && out_valid_ff && !rsp_ch.ready) |-> !skid_valid_ff)
      else $error("readout overflow");

   // no bytes taken while the buffer plays back
   a_no_accept_drain: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DRAIN) |-> !req_ch.ready)
      else $error("byte accepted during readout");

   // reads are issued only during readout, and never past the frame length
   a_issue_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_issue |-> (LEN_W'(rd_addr_ff) < frame_len_ff))
      else $error("read beyond frame");

endmodule : length_prefixed_frame_deframer_core

`default_nettype wire

// File: dv/length_prefixed_frame_deframer_core_tb.sv
// Self-checking testbench for the length-prefixed frame deframer core.
`timescale 1ns / 100ps

module length_prefixed_frame_deframer_core_tb;
   import lpfd_pkg::*;

   localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side
   localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 16;    // quiet time after the last expected word

   // Parser phases of the predictor (its own encoding, not the RTL one-hot).
   typedef enum logic [2:0] {
      HUNTING, LEN_LOW, LEN_HIGH, PAYLOAD, CHECK_HIGH, CHECK_LOW
   } frame_phase_type;

   // Predicts the result words of the deframer and checks the words that arrive.
   class deframe_scoreboard;
      logic [7:0]      start_byte;
      frame_phase_type phase;
      logic [15:0]     frame_len;
      logic [6:0]      byte_count;
      logic [15:0]     check_hold;
      logic [7:0]      payload_store [MAX_PAYLOAD];
      rsp_word_type    words_due [$];
      int              errors;

      function new();
         start_byte = '0;
         phase      = HUNTING;
         frame_len  = '0;
         byte_count = '0;
         check_hold = '0;
         errors     = 0;
         foreach (payload_store[i]) payload_store[i] = '0;
      endfunction

      function void expect_word(logic [1:0] kind, logic [7:0] pb, logic last,
                                logic [15:0] flen, logic [15:0] chk);
         rsp_word_type w;
         w.kind         = kind;
         w.payload_byte = pb;
         w.last         = last;
         w.frame_length = flen;
         w.check_word   = chk;
         words_due.push_back(w);
      endfunction

      // One accepted byte: advance the parser and queue what it emits.
      function void note_rx_byte(logic [7:0] b);
         int len;
         case (phase)
            LEN_LOW: begin
               frame_len = {8'h00, b};
               phase     = LEN_HIGH;
            end
            LEN_HIGH: begin
               frame_len[15:8] = b;
               byte_count      = '0;
               if (frame_len > MAX_PAYLOAD) begin
                  // too long: one error word, no check word seen yet
                  expect_word(KIND_LEN_ERR, 8'h00, 1'b1, frame_len, 16'h0000);
                  phase = HUNTING;
               end else if (frame_len == 16'd0) begin
                  phase = CHECK_HIGH;
               end else begin
                  phase = PAYLOAD;
               end
            end
            PAYLOAD: begin
               if (byte_count < MAX_PAYLOAD) payload_store[byte_count[ADDR_W-1:0]] = b;
               byte_count = byte_count + 7'd1;
               if ({9'd0, byte_count} >= frame_len) phase = CHECK_HIGH;
            end
            CHECK_HIGH: begin
               check_hold = {8'h00, b};
               phase      = CHECK_LOW;
            end
            CHECK_LOW: begin
               check_hold = {check_hold[7:0], b};
               phase      = HUNTING;
               if (frame_len == 16'd0) begin
                  expect_word(KIND_EMPTY, 8'h00, 1'b1, 16'h0000, check_hold);
               end else begin
                  len = (frame_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(frame_len);
                  for (int i = 0; i < len; i++)
                     expect_word(KIND_DATA, payload_store[i], (i + 1 == len),
                                 frame_len, check_hold);
               end
            end
            default: begin
               if (b == start_byte) begin
                  phase      = LEN_LOW;
                  frame_len  = '0;
                  byte_count = '0;
               end
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_word(rsp_word_type got);
         rsp_word_type want;
         if (words_due.size() == 0) begin
            report_mismatch($sformatf("unexpected word %p", got));
         end else begin
            want = words_due.pop_front();
            if (got.kind !== want.kind)
               report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.payload_byte !== want.payload_byte)
               report_mismatch($sformatf("payload_byte %h, want %h",
                                         got.payload_byte, want.payload_byte));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %b, want %b", got.last, want.last));
            if (got.frame_length !== want.frame_length)
               report_mismatch($sformatf("frame_length %h, want %h",
                                         got.frame_length, want.frame_length));
            if (got.check_word !== want.check_word)
               report_mismatch($sformatf("check_word %h, want %h",
                                         got.check_word, want.check_word));
         end
      endtask

      task report_leftovers();
         if (words_due.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived", words_due.size()));
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   lpfd_req_if req_ch ();
   lpfd_rsp_if rsp_ch ();

   length_prefixed_frame_deframer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch)
   );

   deframe_scoreboard sb;
   bit calm [2];            // per side: 1 = no idling for a while (0 sender, 1 receiver)
   bit hold_off_req;        // asks the receiver for one long hold-off
   int frame_bytes_sent;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Idle cycles before the next word; flips into and out of calm stretches.
   function automatic int draw_gap(int side);
      if ($urandom_range(0, 31) == 0) calm[side] = !calm[side];
      return calm[side] ? 0 : int'($urandom_range(0, 7));
   endfunction

   // Offer one byte and wait for it to be taken. Entered and left right after an edge.
   task automatic send_rx_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap(0);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_rx_byte(b);
   endtask

   // Build one frame around the current start byte; optionally cut it short.
   task automatic send_frame(input int len, input bit may_cut);
      logic [7:0]  q [$];
      logic [15:0] flen;
      logic [15:0] chk;
      int          keep;
      flen = len[15:0];
      chk  = 16'($urandom);
      q.push_back(sb.start_byte);
      q.push_back(flen[7:0]);
      q.push_back(flen[15:8]);
      if (len <= MAX_PAYLOAD) begin
         repeat (len) q.push_back(8'($urandom_range(0, 255)));
         q.push_back(chk[15:8]);
         q.push_back(chk[7:0]);
      end
      keep = q.size();
      if (may_cut && $urandom_range(0, 9) == 0) keep = $urandom_range(1, q.size() - 1);
      for (int i = 0; i < keep; i++) send_rx_byte(q[i]);
      frame_bytes_sent += keep;
   endtask

   // Random frames with line noise in between, mostly short payloads.
   task automatic run_frames(input int budget, input bit with_max, input bit with_hold);
      int stop_at;
      int r;
      int len;
      stop_at = frame_bytes_sent + budget;
      if (with_max) begin
         send_frame(MAX_PAYLOAD, 1'b0);
         // readout of the full buffer is now running: stall the receiver behind it
         if (with_hold) hold_off_req = 1'b1;
      end
      while (frame_bytes_sent < stop_at) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_rx_byte(8'($urandom_range(0, 255)));
         r = $urandom_range(0, 99);
         if (r < 10)      len = 0;
         else if (r < 20) len = ($urandom_range(0, 1) == 1) ? 16'hFFFF
                                : $urandom_range(16'hFFFF, MAX_PAYLOAD + 1);
         else if (r < 24) len = MAX_PAYLOAD;
         else             len = $urandom_range(1, 12);
         send_frame(len, 1'b1);
      end
   endtask

   task automatic write_start_byte(input logic [7:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      sb.start_byte  = v;
   endtask

   // Stop sending, wait for every expected word, then let the core go quiet.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Receiver: random back-pressure, one long hold-off on request.
   initial begin : rsp_sink
      rsp_word_type got;
      int           wait_left;
      wait_left     = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind         = rsp_ch.kind;
            got.payload_byte = rsp_ch.payload_byte;
            got.last         = rsp_ch.last;
            got.frame_length = rsp_ch.frame_length;
            got.check_word   = rsp_ch.check_word;
            sb.check_word(got);
            wait_left = draw_gap(1);
         end else if (wait_left > 0) begin
            wait_left--;
         end
         if (hold_off_req) begin
            wait_left    = HOLD_CYCLES;
            hold_off_req = 1'b0;
         end
         rsp_ch.ready <= (wait_left == 0);
      end
   end

   // Ends the run if no word moves on either side for too long.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle = 0;
         else idle++;
      end
      $display("FAIL length_prefixed_frame_deframer_core");
      $finish;
   end

   initial begin : stimulus
      logic [7:0] directed [$];
      sb               = new();
      hold_off_req     = 1'b0;
      frame_bytes_sent = 0;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= 8'h00;
      req_ch.valid    <= 1'b0;
      req_ch.rx_byte  <= 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed, start byte 0x00:
      //  stray byte while hunting, empty frame with check FFFF,
      //  length one past the buffer, length FFFF,
      //  one-byte frame (payload FF, check 0000), two-byte frame.
      directed = '{8'hFF,
                   8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                   8'h00, 8'h41, 8'h00,
                   8'h00, 8'hFF, 8'hFF,
                   8'h00, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h00,
                   8'h00, 8'h02, 8'h00, 8'h00, 8'h80, 8'h12, 8'h34};
      write_start_byte(8'h00);
      foreach (directed[i]) send_rx_byte(directed[i]);
      settle();

      // Random phases, each with its own start byte; the first two open with a
      // full-buffer frame, the second one also with the long receiver stall.
      write_start_byte(8'hFF);
      run_frames(70, 1'b1, 1'b0);
      settle();
      write_start_byte(8'($urandom_range(1, 254)));
      run_frames(70, 1'b1, 1'b1);
      settle();
      write_start_byte(8'($urandom_range(0, 255)));
      run_frames(25, 1'b0, 1'b0);
      settle();

      sb.report_leftovers();
      if (sb.errors == 0) begin
         $display("PASS length_prefixed_frame_deframer_core");
      end else begin
         $display("FAIL length_prefixed_frame_deframer_core");
      end
      $finish;
   end

endmodule
